[src/tea_pkg.sv]
// ----------------------------------------------------------------------------
// Torsion energy accumulator package
// Shared widths, fixed-point constants, style codes and series divisor tables.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int SUM_WIDTH_DEF  = 48;

  // internal coefficient and per-item energy widths
  localparam int KW = 48;
  localparam int EW = 52;

  // shared multiplier
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [31:0] RAD_TO_BAM = 32'd2734261102;
  localparam logic [30:0] PIO2_Q30   = 31'd1686629713;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [29:0] Q29_HALF   = 30'h2000_0000;
  localparam logic [5:0]  DEG_DIV    = 6'd45;
  // 8192 / 45 = 182 + 2 / 45; floor(2^32 / 45)
  localparam logic [7:0]  DEG_WHOLE  = 8'd182;
  localparam logic [26:0] DEG_RECIP  = 27'd95443717;

  localparam logic [2:0] STYLE_NONE    = 3'd0;
  localparam logic [2:0] STYLE_COSINE  = 3'd1;
  localparam logic [2:0] STYLE_COS3    = 3'd2;
  localparam logic [2:0] STYLE_COS4    = 3'd3;
  localparam logic [2:0] STYLE_COS3C   = 3'd4;
  localparam logic [2:0] STYLE_SPARE_A = 3'd5;
  localparam logic [2:0] STYLE_SPARE_B = 3'd6;
  localparam logic [2:0] STYLE_SPARE_C = 3'd7;

  // divisor of series step j
  function automatic logic [6:0] div_const(input logic use_sin, input logic [1:0] j);
    logic [6:0] d;
    case ({use_sin, j})
      3'b000:  d = 7'd56;
      3'b001:  d = 7'd30;
      3'b010:  d = 7'd12;
      3'b011:  d = 7'd2;
      3'b100:  d = 7'd72;
      3'b101:  d = 7'd42;
      3'b110:  d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) of series step j
  function automatic logic [31:0] div_recip(input logic use_sin, input logic [1:0] j);
    logic [31:0] r;
    case ({use_sin, j})
      3'b000:  r = 32'd76695844;
      3'b001:  r = 32'd143165576;
      3'b010:  r = 32'd357913941;
      3'b011:  r = 32'd2147483648;
      3'b100:  r = 32'd59652323;
      3'b101:  r = 32'd102261126;
      3'b110:  r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

endpackage

[src/tea_mul.sv]
// ----------------------------------------------------------------------------
// Torsion energy shared multiplier
// Signed multiply with a registered product, shared by the sequencer's multiply steps.
// ----------------------------------------------------------------------------
module tea_mul (
  input  logic                                  clk_i,
  input  logic signed [tea_pkg::MUL_W-1:0]      a_i,
  input  logic signed [tea_pkg::MUL_W-1:0]      b_i,
  output logic signed [tea_pkg::PROD_W-1:0]     p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

[src/torsion_energy_accumulator.sv]
// ----------------------------------------------------------------------------
// Torsion energy accumulator
// Sums cosine-series torsion energies with saturation; emits total and
// unhandled count on the last term of a group.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in       | input     | in_valid_i/in_ready_o | angle, style, coefficients, phase,
//           |           |                       | multiplicity, last flag
//  out      | output    | out_valid_o/out_ready_i | total_energy_o, unhandled_count_o
//
//  Every cosine term of an item is computed through the one shared multiplier,
//  the cosine style after a degree conversion of the phase; a term whose
//  reduced angle needs the sine series takes an extra multiply.
//  in_ready_o is high only in idle; a last term waits while a result is held.
//  Reset clears the running total, the count and the output valid flag.
// ----------------------------------------------------------------------------
module torsion_energy_accumulator #(
  parameter int COEF_WIDTH = tea_pkg::COEF_WIDTH_DEF,
  parameter int SUM_WIDTH  = tea_pkg::SUM_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           torsion_angle_i,
  input  logic [2:0]                   style_i,
  input  logic signed [COEF_WIDTH-1:0] coef_zero_i,
  input  logic signed [COEF_WIDTH-1:0] coef_one_i,
  input  logic signed [COEF_WIDTH-1:0] coef_two_i,
  input  logic signed [COEF_WIDTH-1:0] coef_three_i,
  input  logic signed [COEF_WIDTH-1:0] coef_four_i,
  input  logic signed [25:0]           phase_degrees_i,
  input  logic [3:0]                   multiplicity_i,
  input  logic                         last_term_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [47:0]           total_energy_o,
  output logic [15:0]                  unhandled_count_o
);

  localparam int KW = tea_pkg::KW;
  localparam int EW = tea_pkg::EW;
  localparam int MW = tea_pkg::MUL_W;
  localparam int PW = tea_pkg::PROD_W;
  localparam int AW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
  localparam logic signed [AW-1:0] SUM_MAX =
    signed'({{(AW-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}});
  localparam logic signed [AW-1:0] SUM_MIN = ~SUM_MAX;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PHI, ST_PHI_W, ST_EQ, ST_EQ_W, ST_EQ_F, ST_ANG, ST_ARG, ST_C0,
    ST_C1, ST_C2, ST_DV, ST_NX, ST_MT, ST_SN, ST_CV, ST_K1, ST_K2, ST_K3, ST_ACC
  } state_e;

  state_e                 state_q;
  logic signed [31:0]     phi_q;
  logic [2:0]             style_q;
  logic signed [KW-1:0]   k0_q, k1_q, k2_q, k3_q, k4_q;
  logic signed [25:0]     deg_q;
  logic [3:0]             n_q;
  logic                   last_q;
  logic [31:0]            bphi_q;
  logic [31:0]            dq_q;
  logic                   dnz_q;
  logic                   deg_neg_q;
  logic [31:0]            beq_q;
  logic [2:0]             term_q;
  logic [31:0]            u_q;
  logic                   use_sin_q;
  logic                   neg_q;
  logic [29:0]            x_q;
  logic [29:0]            x2_q;
  logic [30:0]            div_v_q;
  logic [1:0]             j_q;
  logic [30:0]            t_q;
  logic [31:0]            w_q;
  logic signed [63:0]     ph_q;
  logic signed [EW-1:0]   e_q;
  logic signed [SUM_WIDTH-1:0] sum_q;
  logic [15:0]            cnt_unh_q;
  logic                   out_valid_q;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   mul_q;

  tea_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_q)
  );

  // quadrant reduction
  logic [29:0] f_w, g_w;
  logic        big_w;
  assign f_w   = u_q[29:0];
  assign big_w = f_w > tea_pkg::Q29_HALF;
  assign g_w   = big_w ? 30'(tea_pkg::Q30_ONE - {1'b0, f_w}) : f_w;

  // reciprocal division with one correction
  logic [6:0]  dv_d;
  logic [30:0] q0_w, qc_w;
  logic [37:0] rem_w;
  assign dv_d  = tea_pkg::div_const(use_sin_q, j_q);
  assign q0_w  = mul_q[62:32];
  assign rem_w = 38'(div_v_q) - 38'(q0_w) * 38'(dv_d);
  assign qc_w  = q0_w + 31'(rem_w >= 38'(dv_d));

  // weight 1 +/- cos
  logic [30:0]        c_w;
  logic signed [32:0] cs_w, w_w;
  logic               plus_w;
  assign c_w    = use_sin_q ? mul_q[60:30] : t_q;
  assign cs_w   = neg_q ? -$signed({2'b00, c_w}) : $signed({2'b00, c_w});
  assign plus_w = term_q[0];
  assign w_w    = plus_w ? ($signed({2'b00, tea_pkg::Q30_ONE}) + cs_w)
                         : ($signed({2'b00, tea_pkg::Q30_ONE}) - cs_w);

  // coefficient of the current term
  logic signed [KW-1:0] k_w;
  always_comb begin
    case (term_q)
      3'd2:    k_w = k2_q;
      3'd3:    k_w = k3_q;
      3'd4:    k_w = k4_q;
      default: k_w = k1_q;
    endcase
  end

  logic signed [80:0] p_w, tsh_w;
  logic               is_cos_w;
  assign is_cos_w = style_q == tea_pkg::STYLE_COSINE;
  assign p_w   = ($signed(81'(ph_q)) <<< 16) + $signed({33'b0, mul_q[47:0]});
  assign tsh_w = is_cos_w ? (p_w >>> 30) : (p_w >>> 31);

  logic [2:0] last_idx_w;
  assign last_idx_w = (style_q == tea_pkg::STYLE_COS4) ? 3'd4 : 3'd3;

  // saturating accumulate
  logic signed [AW-1:0] acc_w, sat_w;
  assign acc_w = AW'(sum_q) + AW'(e_q);
  assign sat_w = (acc_w > SUM_MAX) ? SUM_MAX : ((acc_w < SUM_MIN) ? SUM_MIN : acc_w);

  // degree conversion: |eq| * 8192 / 45 = 182 * |eq| + 2 * |eq| / 45
  logic [25:0] mag_w;
  assign mag_w = deg_q[25] ? 26'(-deg_q) : 26'(deg_q);

  logic [26:0] dv2_w;
  logic [21:0] dq0_w;
  logic [27:0] dr_w;
  logic        dge_w;
  logic [33:0] eqm_w;
  assign dv2_w = {mag_w, 1'b0};
  assign dq0_w = mul_q[53:32];
  assign dr_w  = 28'(dv2_w) - 28'(dq0_w) * 28'(tea_pkg::DEG_DIV);
  assign dge_w = dr_w >= 28'(tea_pkg::DEG_DIV);
  assign eqm_w = 34'(mag_w) * 34'(tea_pkg::DEG_WHOLE) + 34'(dq_q)
               + 34'(deg_neg_q & dnz_q);

  logic out_load_w;
  assign out_load_w = (state_q == ST_ACC) && last_q && (!out_valid_q || out_ready_i);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PHI: begin
        mul_a = MW'(phi_q);
        mul_b = $signed({2'b00, tea_pkg::RAD_TO_BAM});
      end
      ST_EQ: begin
        mul_a = $signed(MW'(dv2_w));
        mul_b = $signed(MW'(tea_pkg::DEG_RECIP));
      end
      ST_ANG: begin
        mul_a = is_cos_w ? $signed(MW'(n_q)) : $signed(MW'(term_q));
        mul_b = $signed({2'b00, bphi_q});
      end
      ST_C0: begin
        mul_a = $signed(MW'(g_w));
        mul_b = $signed(MW'(tea_pkg::PIO2_Q30));
      end
      ST_C1: begin
        mul_a = $signed(MW'(mul_q[59:30]));
        mul_b = $signed(MW'(mul_q[59:30]));
      end
      ST_C2: begin
        mul_a = $signed(MW'(mul_q[59:30]));
        mul_b = $signed(MW'(tea_pkg::div_recip(use_sin_q, 2'd0)));
      end
      ST_NX: begin
        mul_a = $signed(MW'(x2_q));
        mul_b = $signed(MW'(t_q));
      end
      ST_MT: begin
        mul_a = $signed(MW'(mul_q[60:30]));
        mul_b = $signed(MW'(tea_pkg::div_recip(use_sin_q, j_q)));
      end
      ST_SN: begin
        mul_a = $signed(MW'(x_q));
        mul_b = $signed(MW'(t_q));
      end
      ST_K1: begin
        mul_a = MW'($signed(k_w[KW-1:16]));
        mul_b = $signed({2'b00, w_q});
      end
      ST_K2: begin
        mul_a = $signed(MW'(k_w[15:0]));
        mul_b = $signed({2'b00, w_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_unh_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load_w) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            phi_q   <= torsion_angle_i;
            style_q <= style_i;
            k0_q    <= KW'(coef_zero_i);
            k1_q    <= KW'(coef_one_i);
            k2_q    <= KW'(coef_two_i);
            k3_q    <= KW'(coef_three_i);
            k4_q    <= KW'(coef_four_i);
            deg_q   <= phase_degrees_i;
            n_q     <= multiplicity_i;
            last_q  <= last_term_i;
            state_q <= ST_PHI;
          end
        end
        ST_PHI: begin
          state_q <= ST_PHI_W;
        end
        ST_PHI_W: begin
          bphi_q    <= mul_q[61:30];
          term_q    <= 3'd1;
          e_q       <= (style_q == tea_pkg::STYLE_COS3C) ? EW'(k0_q) : '0;
          deg_neg_q <= deg_q[25];
          beq_q     <= '0;
          case (style_q)
            tea_pkg::STYLE_COSINE: state_q <= ST_EQ;
            tea_pkg::STYLE_COS3,
            tea_pkg::STYLE_COS4,
            tea_pkg::STYLE_COS3C:  state_q <= ST_ANG;
            default: begin
              if (cnt_unh_q != 16'hFFFF) begin
                cnt_unh_q <= cnt_unh_q + 16'd1;
              end
              state_q <= ST_ACC;
            end
          endcase
        end
        ST_EQ: begin
          state_q <= ST_EQ_W;
        end
        ST_EQ_W: begin
          dq_q    <= 32'(dq0_w) + 32'(dge_w);
          dnz_q   <= dge_w ? (dr_w != 28'(tea_pkg::DEG_DIV)) : (dr_w != 28'd0);
          state_q <= ST_EQ_F;
        end
        ST_EQ_F: begin
          beq_q   <= deg_neg_q ? 32'(-eqm_w) : eqm_w[31:0];
          state_q <= ST_ANG;
        end
        ST_ANG: begin
          state_q <= ST_ARG;
        end
        ST_ARG: begin
          u_q     <= mul_q[31:0] - beq_q;
          state_q <= ST_C0;
        end
        ST_C0: begin
          use_sin_q <= u_q[30] ^ big_w;
          neg_q     <= u_q[31] ^ u_q[30];
          state_q   <= ST_C1;
        end
        ST_C1: begin
          x_q     <= mul_q[59:30];
          state_q <= ST_C2;
        end
        ST_C2: begin
          x2_q    <= mul_q[59:30];
          div_v_q <= {1'b0, mul_q[59:30]};
          j_q     <= 2'd0;
          state_q <= ST_DV;
        end
        ST_DV: begin
          t_q <= tea_pkg::Q30_ONE - qc_w;
          if (j_q == 2'd3) begin
            state_q <= use_sin_q ? ST_SN : ST_CV;
          end else begin
            j_q     <= j_q + 2'd1;
            state_q <= ST_NX;
          end
        end
        ST_NX: begin
          state_q <= ST_MT;
        end
        ST_MT: begin
          div_v_q <= mul_q[60:30];
          state_q <= ST_DV;
        end
        ST_SN: begin
          state_q <= ST_CV;
        end
        ST_CV: begin
          w_q     <= w_w[31:0];
          state_q <= ST_K1;
        end
        ST_K1: begin
          state_q <= ST_K2;
        end
        ST_K2: begin
          ph_q    <= mul_q[63:0];
          state_q <= ST_K3;
        end
        ST_K3: begin
          e_q <= e_q + tsh_w[EW-1:0];
          if (is_cos_w || term_q == last_idx_w) begin
            state_q <= ST_ACC;
          end else begin
            term_q  <= term_q + 3'd1;
            state_q <= ST_ANG;
          end
        end
        ST_ACC: begin
          if (!last_q) begin
            sum_q   <= sat_w[SUM_WIDTH-1:0];
            state_q <= ST_IDLE;
          end else if (out_load_w) begin
            total_energy_o    <= sat_w[47:0];
            unhandled_count_o <= cnt_unh_q;
            out_valid_q       <= 1'b1;
            sum_q             <= '0;
            cnt_unh_q         <= '0;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted transaction did not make the block busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EQ_W |-> dr_w < 28'({tea_pkg::DEG_DIV, 1'b0}))
    else $error("degree conversion remainder out of range");

  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_K1 |-> w_q <= 32'h8000_0000)
    else $error("cosine weight out of range");

  a_series_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NX |-> t_q <= tea_pkg::Q30_ONE)
    else $error("series term out of range");

endmodule

[tb/sv/tea_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Torsion energy checker
// Watches both channels, predicts each group total and unhandled count from
// accepted terms, and compares them with the emitted results in order.
// ----------------------------------------------------------------------------
module tea_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] torsion_angle_i,
  input  logic [2:0]         style_i,
  input  logic signed [31:0] coef_zero_i,
  input  logic signed [31:0] coef_one_i,
  input  logic signed [31:0] coef_two_i,
  input  logic signed [31:0] coef_three_i,
  input  logic signed [31:0] coef_four_i,
  input  logic signed [25:0] phase_degrees_i,
  input  logic [3:0]         multiplicity_i,
  input  logic               last_term_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [47:0] total_energy_i,
  input  logic [15:0]        unhandled_count_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);

  localparam longint Q30 = 64'sd1073741824;
  localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 47);

  logic signed [47:0] totals_q[$];
  logic [15:0]        counts_q[$];
  longint             run_sum;
  int unsigned        run_unhandled;

  function automatic longint poly_cos(input longint x);
    longint x2, t;
    x2 = (x * x) >>> 30;
    t = Q30 - x2 / 56;
    t = Q30 - ((x2 * t) >>> 30) / 30;
    t = Q30 - ((x2 * t) >>> 30) / 12;
    return Q30 - ((x2 * t) >>> 30) / 2;
  endfunction

  function automatic longint poly_sin(input longint x);
    longint x2, t;
    x2 = (x * x) >>> 30;
    t = Q30 - x2 / 72;
    t = Q30 - ((x2 * t) >>> 30) / 42;
    t = Q30 - ((x2 * t) >>> 30) / 20;
    t = Q30 - ((x2 * t) >>> 30) / 6;
    return (x * t) >>> 30;
  endfunction

  function automatic longint bam_cosine(input logic [31:0] u);
    longint f, x, c0, s0;
    f = longint'(u[29:0]);
    if (f <= (Q30 >>> 1)) begin
      x = (f * 64'sd1686629713) >>> 30;
      c0 = poly_cos(x);
      s0 = poly_sin(x);
    end else begin
      x = ((Q30 - f) * 64'sd1686629713) >>> 30;
      c0 = poly_sin(x);
      s0 = poly_cos(x);
    end
    case (u[31:30])
      2'd0:    return c0;
      2'd1:    return -s0;
      2'd2:    return -c0;
      default: return s0;
    endcase
  endfunction

  // floor(k*w / 2^s) without overflowing 64 bits
  function automatic longint scaled_product(input longint k, input longint w, input int s);
    longint kh, kl, a, b, hi, rem;
    kh = k >>> 16;
    kl = k - kh * 65536;
    a = kh * w;
    b = kl * w;
    hi = a >>> (s - 16);
    rem = a - hi * (64'sd1 <<< (s - 16));
    return hi + ((rem * 65536 + b) >>> s);
  endfunction

  function automatic longint series_term_energy(input logic [31:0] bphi, input longint k1,
                                                input longint k2, input longint k3,
                                                input longint k4, input bit with4);
    longint e;
    logic [31:0] m2, m3, m4;
    m2 = bphi * 32'd2;
    m3 = bphi * 32'd3;
    m4 = bphi * 32'd4;
    e = scaled_product(k1, Q30 + bam_cosine(bphi), 31);
    e += scaled_product(k2, Q30 - bam_cosine(m2), 31);
    e += scaled_product(k3, Q30 + bam_cosine(m3), 31);
    if (with4) e += scaled_product(k4, Q30 - bam_cosine(m4), 31);
    return e;
  endfunction

  function automatic void add_energy(input longint e);
    if (e > 0 && run_sum > SUM_MAX - e) run_sum = SUM_MAX;
    else if (e < 0 && run_sum < SUM_MIN - e) run_sum = SUM_MIN;
    else run_sum += e;
  endfunction

  task automatic absorb_term();
    longint phi, deg, scaled, q, wide, k1, k2, k3;
    logic [31:0] bphi, beq, arg;
    phi = longint'(torsion_angle_i);
    wide = phi * 64'sd2734261102;
    bphi = 32'(wide >>> 30);
    k1 = longint'(coef_one_i);
    k2 = longint'(coef_two_i);
    k3 = longint'(coef_three_i);
    case (style_i)
      tea_pkg::STYLE_COSINE: begin
        deg = longint'(phase_degrees_i);
        scaled = deg * 65536;
        q = (scaled >= 0) ? scaled / 360 : -((-scaled + 359) / 360);
        beq = 32'(q);
        arg = 32'(multiplicity_i) * bphi - beq;
        add_energy(scaled_product(k1, Q30 + bam_cosine(arg), 30));
      end
      tea_pkg::STYLE_COS3: add_energy(series_term_energy(bphi, k1, k2, k3, 64'sd0, 1'b0));
      tea_pkg::STYLE_COS4: add_energy(series_term_energy(bphi, k1, k2, k3,
                                                         longint'(coef_four_i), 1'b1));
      tea_pkg::STYLE_COS3C: add_energy(longint'(coef_zero_i) +
                                       series_term_energy(bphi, k1, k2, k3, 64'sd0, 1'b0));
      default: if (run_unhandled < 65535) run_unhandled++;
    endcase
    if (last_term_i) begin
      totals_q.push_back(48'(run_sum));
      counts_q.push_back(16'(run_unhandled));
      run_sum = 0;
      run_unhandled = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [47:0] exp_total;
    logic [15:0]        exp_count;
    if (!rst_ni) begin
      run_sum = 0;
      run_unhandled = 0;
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) absorb_term();
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (totals_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result total %0d", total_energy_i);
        end else begin
          exp_total = totals_q.pop_front();
          exp_count = counts_q.pop_front();
          if (exp_total !== total_energy_i || exp_count !== unhandled_count_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: total exp %0d got %0d, count exp %0d got %0d",
                       exp_total, total_energy_i, exp_count, unhandled_count_i);
          end
        end
      end
    end
  end

  assign pending_o = totals_q.size();

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Torsion energy accumulator testbench
// Drives directed and random torsion terms in groups with bursty input and
// stalling output; a checker predicts every group result and compares it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_TERMS = 1030;
  localparam int IDLE_LIMIT   = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] torsion_angle_i;
  logic [2:0]         style_i;
  logic signed [31:0] coef_zero_i, coef_one_i, coef_two_i, coef_three_i, coef_four_i;
  logic signed [25:0] phase_degrees_i;
  logic [3:0]         multiplicity_i;
  logic               last_term_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [47:0] total_energy_o;
  logic [15:0]        unhandled_count_o;

  int  fail_count, pending, results_seen;
  int  terms_sent, idle_cycles;
  bit  hold_off, stimulus_done;

  torsion_energy_accumulator u_top (.*);

  tea_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .torsion_angle_i, .style_i,
    .coef_zero_i, .coef_one_i, .coef_two_i, .coef_three_i, .coef_four_i,
    .phase_degrees_i, .multiplicity_i, .last_term_i, .out_valid_i(out_valid_o),
    .out_ready_i, .total_energy_i(total_energy_o), .unhandled_count_i(unhandled_count_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 20'hfffff)) - 32'sh80000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [25:0] pick_phase();
    int unsigned r;
    r = $urandom_range(0, 47185920);
    return 26'(int'(r) - 23592960);
  endfunction

  task automatic send_term(input logic [31:0] ang, input logic [2:0] sty,
                           input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3,
                           input logic [31:0] k4, input logic [25:0] ph,
                           input logic [3:0] n, input logic lst);
    torsion_angle_i <= ang;
    style_i <= sty;
    coef_zero_i <= k0;
    coef_one_i <= k1;
    coef_two_i <= k2;
    coef_three_i <= k3;
    coef_four_i <= k4;
    phase_degrees_i <= ph;
    multiplicity_i <= n;
    last_term_i <= lst;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    terms_sent++;
  endtask

  task automatic send_random(input logic lst);
    logic [2:0] sty;
    sty = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    send_term(pick_word(), sty, pick_word(), pick_word(), pick_word(), pick_word(),
              pick_word(), pick_phase(), 4'($urandom_range(0, 15)), lst);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: stall pattern plus one long hold-off
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else if (($urandom_range(0, 3) == 0) && !stimulus_done) out_ready_i <= 1'b0;
      else out_ready_i <= 1'b1;
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL torsion_energy_accumulator");
        $finish;
      end
    end
  end

  initial begin
    int burst, grp;
    in_valid_i = 1'b0;
    torsion_angle_i = '0; style_i = '0; coef_zero_i = '0; coef_one_i = '0;
    coef_two_i = '0; coef_three_i = '0; coef_four_i = '0; phase_degrees_i = '0;
    multiplicity_i = '0; last_term_i = 1'b0;
    hold_off = 1'b0; stimulus_done = 1'b0; terms_sent = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed terms: every style, extreme fields, runs of extreme coefficients of both signs
    send_term(32'h0, tea_pkg::STYLE_NONE, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    send_term(32'h7fff_ffff, tea_pkg::STYLE_COSINE, '0, 32'h7fff_ffff, '0, '0, '0,
              26'sd23592960, 4'd15, 1'b0);
    send_term(32'h8000_0000, tea_pkg::STYLE_COSINE, '0, 32'h8000_0000, '0, '0, '0,
              -26'sd23592960, 4'd0, 1'b0);
    send_term(32'h1000_0000, tea_pkg::STYLE_COSINE, '0, 32'h0001_0000, '0, '0, '0,
              26'sd11796480, 4'd12, 1'b1);
    send_term(32'h1234_5678, tea_pkg::STYLE_COS3, 32'hffff_ffff, 32'h0003_0000,
              32'hfffe_0000, 32'h0001_8000, 32'h7fff_ffff, 26'h3ff_ffff, 4'd7, 1'b0);
    send_term(32'hedcb_a988, tea_pkg::STYLE_COS4, '0, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, '0, '0, 1'b0);
    send_term(32'h0, tea_pkg::STYLE_COS3C, 32'h8000_0000, 32'h8000_0000, '0, 32'h8000_0000,
              '0, '0, '0, 1'b0);
    send_term(32'h3243_f6a8, tea_pkg::STYLE_SPARE_A, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    send_term(32'h0, tea_pkg::STYLE_SPARE_B, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    send_term(32'h0, tea_pkg::STYLE_SPARE_C, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    for (int i = 0; i < 8; i++)
      send_term(32'h0, tea_pkg::STYLE_COS3C, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0,
                32'h7fff_ffff, '0, '0, '0, i == 7);
    for (int i = 0; i < 6; i++)
      send_term(32'h0, tea_pkg::STYLE_COS3C, 32'h8000_0000, 32'h8000_0000, 32'h0,
                32'h8000_0000, '0, '0, '0, i == 5);
    drop_valid();

    // long hold-off on the receiver while terms keep coming
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++) send_random(1'b1);
      end
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drop_valid();

    // pause until every result is back
    while (pending != 0) @(posedge clk_i);

    while (terms_sent < RANDOM_TERMS) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst; i++) begin
        grp = $urandom_range(0, 7);
        send_random(grp == 0);
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 200)) @(posedge clk_i);
      end
    end
    send_random(1'b1);
    drop_valid();
    stimulus_done = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d torsion terms, %0d group totals checked", terms_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS torsion_energy_accumulator");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL torsion_energy_accumulator");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tea_pkg.sv
src/tea_mul.sv
src/torsion_energy_accumulator.sv
tb/sv/tea_checker.sv
tb/sv/tb_top.sv
